>>> hdl/qpd_pkg.sv
// Shared types, character codes and helpers for the quoted-printable decoder.
package qpd_pkg;

    localparam logic [7:0] CH_EQ  = 8'h3D;
    localparam logic [7:0] CH_US  = 8'h5F;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    // One packet of decoded output: up to three bytes caused by one input beat.
    typedef struct packed {
        logic [7:0] byte2;
        logic [7:0] byte1;
        logic [7:0] byte0;
        logic [1:0] last_idx;   // number of bytes minus one
        logic       recovered;
    } qpd_pkt_t;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [4:0] res;
        res = 5'h00;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            res = {1'b1, ch[3:0]};
        end
        else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))
        begin
            res = {1'b1, ch[3:0] + 4'd9};
        end
        return res;
    endfunction

    // Upper-case hex character for a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] res;
        if (d > 4'd9)
        begin
            res = {4'h0, d} + 8'h37;
        end
        else
        begin
            res = {4'h0, d} + 8'h30;
        end
        return res;
    endfunction

endpackage

>>> hdl/qpd_front.sv
// Front end: escape and line-end tracking, builds at most one output packet per input beat.
module qpd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    input  logic            cfg_data,
    input  logic            in_valid,
    input  logic [7:0]      in_byte,
    input  logic            queue_full,
    output logic            in_ready,
    output logic            push,
    output qpd_pkg::qpd_pkt_t push_pkt
);
    import qpd_pkg::*;

    logic       q_mode_reg;
    logic       in_escape_reg, in_escape_next;
    logic       have_nibble_reg, have_nibble_next;
    logic [3:0] high_nibble_reg, high_nibble_next;
    logic       expect_lf_reg, expect_lf_next;

    logic       accept;
    logic       esc, hn, elf;
    logic [3:0] nib;
    logic [4:0] hex;
    logic       emit;
    qpd_pkt_t   pkt;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign hex      = hex_decode(in_byte);

    always_comb
    begin
        // Drop a pending CR, and with it any escape, unless LF follows
        if (expect_lf_reg && in_byte != CH_LF)
        begin
            esc = 1'b0;
            hn  = 1'b0;
            nib = 4'h0;
            elf = 1'b0;
        end
        else
        begin
            esc = in_escape_reg;
            hn  = have_nibble_reg;
            nib = high_nibble_reg;
            elf = expect_lf_reg;
        end

        in_escape_next   = esc;
        have_nibble_next = hn;
        high_nibble_next = nib;
        expect_lf_next   = elf;
        emit             = 1'b0;
        pkt.byte0        = in_byte;
        pkt.byte1        = in_byte;
        pkt.byte2        = in_byte;
        pkt.last_idx     = 2'd0;
        pkt.recovered    = 1'b0;

        if (esc)
        begin
            if (hex[4])
            begin
                if (hn)
                begin
                    emit             = 1'b1;
                    pkt.byte0        = {nib, hex[3:0]};
                    in_escape_next   = 1'b0;
                    have_nibble_next = 1'b0;
                    high_nibble_next = 4'h0;
                    expect_lf_next   = 1'b0;
                end
                else
                begin
                    have_nibble_next = 1'b1;
                    high_nibble_next = hex[3:0];
                end
            end
            else if (in_byte == CH_CR)
            begin
                expect_lf_next = 1'b1;
            end
            else if (in_byte == CH_LF && !hn)
            begin
                in_escape_next   = 1'b0;
                have_nibble_next = 1'b0;
                high_nibble_next = 4'h0;
                expect_lf_next   = 1'b0;
            end
            else
            begin
                // Malformed escape: replay '=', the pending digit if any, then the byte if printable
                emit          = 1'b1;
                pkt.recovered = 1'b1;
                pkt.byte0     = CH_EQ;
                if (hn)
                begin
                    pkt.byte1    = hex_char(nib);
                    pkt.last_idx = 2'd1;
                    if (in_byte >= CH_BANG && in_byte <= CH_TILDE && in_byte != CH_EQ)
                    begin
                        pkt.byte2    = in_byte;
                        pkt.last_idx = 2'd2;
                    end
                end
                else if (in_byte >= CH_BANG && in_byte <= CH_TILDE && in_byte != CH_EQ)
                begin
                    pkt.byte1    = in_byte;
                    pkt.last_idx = 2'd1;
                end
                in_escape_next   = 1'b0;
                have_nibble_next = 1'b0;
                high_nibble_next = 4'h0;
                expect_lf_next   = 1'b0;
            end
        end
        else
        begin
            if ((in_byte >= CH_SP && in_byte <= CH_TILDE) || in_byte == CH_TAB)
            begin
                if (in_byte == CH_EQ)
                begin
                    in_escape_next = 1'b1;
                end
                else if (q_mode_reg && in_byte == CH_US)
                begin
                    emit      = 1'b1;
                    pkt.byte0 = CH_SP;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            else if (in_byte == CH_LF)
            begin
                emit           = 1'b1;
                expect_lf_next = 1'b0;
            end
            else if (in_byte == CH_CR)
            begin
                expect_lf_next = 1'b1;
            end
        end
    end

    assign push     = accept && emit;
    assign push_pkt = pkt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_mode_reg      <= 1'b0;
            in_escape_reg   <= 1'b0;
            have_nibble_reg <= 1'b0;
            high_nibble_reg <= 4'h0;
            expect_lf_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                q_mode_reg <= cfg_data;
            end
            if (accept)
            begin
                in_escape_reg   <= in_escape_next;
                have_nibble_reg <= have_nibble_next;
                high_nibble_reg <= high_nibble_next;
                expect_lf_reg   <= expect_lf_next;
            end
        end
    end

endmodule

>>> hdl/qpd_fifo.sv
// Short packet queue between the front end and the output sequencer.
module qpd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  qpd_pkg::qpd_pkt_t push_pkt,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output qpd_pkg::qpd_pkt_t head_pkt
);
    import qpd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    qpd_pkt_t      slots [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_pkt = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_pkt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/qpd_back.sv
// Output sequencer: walks the head packet byte by byte into the output register.
module qpd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  qpd_pkg::qpd_pkt_t head_pkt,
    output logic              pop,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [7:0]        out_byte,
    output logic              out_recovered,
    output logic              out_last
);
    import qpd_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_rec_reg;
    logic       out_last_reg;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       take;
    logic       at_end;
    logic [7:0] sel_byte;

    assign load   = !out_valid_reg || out_ready;
    assign take   = load && !empty;
    assign at_end = (idx_reg == head_pkt.last_idx);
    assign pop    = take && at_end;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sel_byte = head_pkt.byte0;
            2'd1:    sel_byte = head_pkt.byte1;
            default: sel_byte = head_pkt.byte2;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            idx_next       = at_end ? 2'd0 : idx_reg + 2'd1;
        end
        else if (load)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_byte_reg <= sel_byte;
            out_rec_reg  <= head_pkt.recovered;
            out_last_reg <= at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign out_recovered = out_rec_reg;
    assign out_last      = out_last_reg;

endmodule

>>> hdl/quoted_printable_decoder_top.sv
// Quoted-printable decoder (body and Q mode): front end, packet queue, output sequencer.
// Takes one encoded byte per cycle when the packet queue has room, and gives one
// decoded byte per cycle while m_axis_tready is high. Each input beat that yields
// output pushes one packet of one to three bytes; the sequencer sends those bytes on
// consecutive cycles, so the sustained rate is one input beat per cycle for ordinary
// text, and a malformed escape costs one output beat for each byte it replays.
// cfg_data sets Q mode (underscore decodes to space); write it only while no beats are
// in flight.
module quoted_printable_decoder_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] recovered
    output logic       m_axis_tlast
);
    import qpd_pkg::*;

    logic     push;
    logic     pop;
    logic     full;
    logic     empty;
    qpd_pkt_t push_pkt;
    qpd_pkt_t head_pkt;

    assign cfg_ready = 1'b1;

    qpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_byte    (s_axis_tdata),
        .queue_full (full),
        .in_ready   (s_axis_tready),
        .push       (push),
        .push_pkt   (push_pkt)
    );

    qpd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_pkt (push_pkt),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head_pkt (head_pkt)
    );

    qpd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (empty),
        .head_pkt      (head_pkt),
        .pop           (pop),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .out_byte      (m_axis_tdata),
        .out_recovered (m_axis_tuser),
        .out_last      (m_axis_tlast)
    );

endmodule

>>> verif/tb_quoted_printable_decoder_top.sv
// Self-checking testbench for the quoted-printable decoder top level.
`timescale 1ns / 100ps

module tb_quoted_printable_decoder_top;

    import qpd_pkg::*;

    // One decoded output beat as it should appear on the master side.
    typedef struct packed {
        logic [7:0] data;
        logic       rec;
        logic       last;
    } qp_beat_t;

    // One directed stimulus row; typed rows carry their own expected beats.
    typedef struct packed {
        bit         q;
        logic [7:0] ch;
        bit         typed;
        logic [1:0] n_out;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        bit         rec;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tuser;           // [0] recovered
    logic       m_axis_tlast;

    // Decoder state mirrored by the predictor
    bit         q_on = 1'b0;
    bit         esc_open = 1'b0;
    bit         nib_held = 1'b0;
    logic [3:0] nib_hi = 4'h0;
    bit         cr_held = 1'b0;

    qp_beat_t   decoded_q [$];
    logic [7:0] plan [$];

    int         mismatches = 0;
    int         bytes_sent = 0;
    int         beats_seen = 0;
    int         recovered_seen = 0;
    int         cfg_writes = 0;
    bit         tx_calm = 1'b0;
    bit         rx_calm = 1'b0;
    int         rx_stall = 0;

    // Directed rows: q mode, byte, typed, count, bytes, recovered
    dir_row_t dir_rows [30] = '{
        '{1'b0, 8'h41,    1'b1, 2'd1, 8'h41,    8'h00, 8'h00, 1'b0},   // plain letter
        '{1'b0, 8'hFF,    1'b1, 2'd0, 8'h00,    8'h00, 8'h00, 1'b0},   // 8-bit byte dropped
        '{1'b0, CH_US,    1'b1, 2'd1, CH_US,    8'h00, 8'h00, 1'b0},   // underscore, Q off
        '{1'b0, CH_TILDE, 1'b1, 2'd1, CH_TILDE, 8'h00, 8'h00, 1'b0},
        '{1'b0, CH_EQ,    1'b1, 2'd0, 8'h00,    8'h00, 8'h00, 1'b0},   // =4a
        '{1'b0, 8'h34,    1'b1, 2'd0, 8'h00,    8'h00, 8'h00, 1'b0},
        '{1'b0, 8'h61,    1'b1, 2'd1, 8'h4A,    8'h00, 8'h00, 1'b0},
        '{1'b0, CH_EQ,    1'b1, 2'd0, 8'h00,    8'h00, 8'h00, 1'b0},   // soft break, CRLF
        '{1'b0, CH_CR,    1'b1, 2'd0, 8'h00,    8'h00, 8'h00, 1'b0},
        '{1'b0, CH_LF,    1'b1, 2'd0, 8'h00,    8'h00, 8'h00, 1'b0},
        '{1'b0, CH_CR,    1'b1, 2'd0, 8'h00,    8'h00, 8'h00, 1'b0},   // CRLF to LF
        '{1'b0, CH_LF,    1'b1, 2'd1, CH_LF,    8'h00, 8'h00, 1'b0},
        '{1'b0, CH_CR,    1'b1, 2'd0, 8'h00,    8'h00, 8'h00, 1'b0},   // lone CR dropped
        '{1'b0, 8'h42,    1'b1, 2'd1, 8'h42,    8'h00, 8'h00, 1'b0},
        '{1'b0, CH_EQ,    1'b1, 2'd0, 8'h00,    8'h00, 8'h00, 1'b0},   // =AG replays three
        '{1'b0, 8'h41,    1'b1, 2'd0, 8'h00,    8'h00, 8'h00, 1'b0},
        '{1'b0, 8'h47,    1'b1, 2'd3, CH_EQ,    8'h41, 8'h47, 1'b1},
        '{1'b0, CH_EQ,    1'b1, 2'd0, 8'h00,    8'h00, 8'h00, 1'b0},   // soft break, bare LF
        '{1'b0, CH_LF,    1'b1, 2'd0, 8'h00,    8'h00, 8'h00, 1'b0},
        '{1'b0, CH_EQ,    1'b1, 2'd0, 8'h00,    8'h00, 8'h00, 1'b0},   // LF after high digit
        '{1'b0, 8'h43,    1'b1, 2'd0, 8'h00,    8'h00, 8'h00, 1'b0},
        '{1'b0, CH_LF,    1'b1, 2'd2, CH_EQ,    8'h43, 8'h00, 1'b1},
        '{1'b0, CH_EQ,    1'b1, 2'd0, 8'h00,    8'h00, 8'h00, 1'b0},   // space not replayed
        '{1'b0, 8'h30,    1'b1, 2'd0, 8'h00,    8'h00, 8'h00, 1'b0},
        '{1'b0, CH_SP,    1'b1, 2'd2, CH_EQ,    8'h30, 8'h00, 1'b1},
        '{1'b0, CH_EQ,    1'b0, 2'd0, 8'h00,    8'h00, 8'h00, 1'b0},   // lone CR in escape
        '{1'b0, 8'h41,    1'b0, 2'd0, 8'h00,    8'h00, 8'h00, 1'b0},
        '{1'b0, CH_CR,    1'b0, 2'd0, 8'h00,    8'h00, 8'h00, 1'b0},
        '{1'b0, 8'h78,    1'b0, 2'd0, 8'h00,    8'h00, 8'h00, 1'b0},
        '{1'b1, CH_US,    1'b1, 2'd1, CH_SP,    8'h00, 8'h00, 1'b0}    // underscore, Q on
    };

    quoted_printable_decoder_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 clk = ~clk;

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return int'(c - 8'h30);
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return int'(c - 8'h41) + 10;
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            return int'(c - 8'h61) + 10;
        end
        return -1;
    endfunction

    function automatic void drop_escape();
        esc_open = 1'b0;
        nib_held = 1'b0;
        nib_hi = 4'h0;
        cr_held = 1'b0;
    endfunction

    // Advance the mirrored state by one encoded byte and list the beats it yields.
    function automatic void decode_char(input logic [7:0] c, output qp_beat_t outs [3],
                                        output int n);
        int v;
        n = 0;
        v = nibble_of(c);
        outs[0] = '0;
        outs[1] = '0;
        outs[2] = '0;
        if (cr_held && c != CH_LF)
        begin
            drop_escape();
        end
        if (esc_open)
        begin
            if (v >= 0)
            begin
                if (nib_held)
                begin
                    outs[n] = '{{nib_hi, v[3:0]}, 1'b0, 1'b0};
                    n++;
                    drop_escape();
                end
                else
                begin
                    nib_held = 1'b1;
                    nib_hi = v[3:0];
                end
            end
            else if (c == CH_CR)
            begin
                cr_held = 1'b1;
            end
            else if (c == CH_LF && !nib_held)
            begin
                drop_escape();
            end
            else
            begin
                // malformed escape: replay '=', the held digit, then the byte if printable
                outs[n] = '{CH_EQ, 1'b1, 1'b0};
                n++;
                if (nib_held)
                begin
                    outs[n] = '{{4'h0, nib_hi} + ((nib_hi > 4'd9) ? 8'h37 : 8'h30), 1'b1, 1'b0};
                    n++;
                end
                if (c >= CH_BANG && c <= CH_TILDE && c != CH_EQ)
                begin
                    outs[n] = '{c, 1'b1, 1'b0};
                    n++;
                end
                drop_escape();
            end
        end
        else if ((c >= CH_SP && c <= CH_TILDE) || c == CH_TAB)
        begin
            if (c == CH_EQ)
            begin
                esc_open = 1'b1;
            end
            else
            begin
                outs[n] = '{(q_on && c == CH_US) ? CH_SP : c, 1'b0, 1'b0};
                n++;
            end
        end
        else if (c == CH_LF)
        begin
            outs[n] = '{CH_LF, 1'b0, 1'b0};
            n++;
            cr_held = 1'b0;
        end
        else if (c == CH_CR)
        begin
            cr_held = 1'b1;
        end
        if (n > 0)
        begin
            outs[n - 1].last = 1'b1;
        end
    endfunction

    function automatic bit ignored(input logic [7:0] c);
        return !((c >= CH_SP && c <= CH_TILDE) || c == CH_TAB || c == CH_LF || c == CH_CR);
    endfunction

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap(input bit calm);
        int k;
        k = $urandom_range(0, 99);
        if (calm || k < 65)
        begin
            return 0;
        end
        if (k < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] hex_digit();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
        begin
            return 8'(8'h30 + v);
        end
        return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
    endfunction

    // Queue one random token: mostly well-formed text and escapes, some broken ones and noise.
    function automatic void plan_token();
        int k;
        logic [7:0] c;
        k = $urandom_range(0, 99);
        if (k < 40)
        begin
            do
            begin
                c = 8'($urandom_range(32, 126));
            end
            while (c == CH_EQ);
            plan.push_back(c);
        end
        else if (k < 45)
        begin
            plan.push_back(CH_US);
        end
        else if (k < 58)
        begin
            plan.push_back(CH_EQ);
            plan.push_back(hex_digit());
            plan.push_back(hex_digit());
        end
        else if (k < 62)
        begin
            plan.push_back(CH_EQ);
            plan.push_back(CH_CR);
            plan.push_back(CH_LF);
        end
        else if (k < 65)
        begin
            plan.push_back(CH_EQ);
            plan.push_back(CH_LF);
        end
        else if (k < 71)
        begin
            plan.push_back(CH_CR);
            plan.push_back(CH_LF);
        end
        else if (k < 74)
        begin
            plan.push_back(CH_LF);
        end
        else if (k < 77)
        begin
            plan.push_back(CH_CR);
        end
        else if (k < 89)
        begin
            // broken escape, some with a CR that is not followed by LF
            plan.push_back(CH_EQ);
            if ($urandom_range(0, 1))
            begin
                plan.push_back(hex_digit());
            end
            if (k >= 84)
            begin
                plan.push_back(CH_CR);
            end
            plan.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            plan.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // Drive one beat, hold it until taken, then queue what it should decode to.
    task automatic send_byte(input dir_row_t r);
        int gap;
        int n;
        qp_beat_t outs [3];
        if ($urandom_range(0, 19) == 0)
        begin
            tx_calm = !tx_calm;
        end
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= r.ch;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        decode_char(r.ch, outs, n);
        if (r.typed)
        begin
            n = r.n_out;
            outs[0] = '{r.b0, r.rec, n == 1};
            outs[1] = '{r.b1, r.rec, n == 2};
            outs[2] = '{r.b2, r.rec, n == 3};
        end
        for (int i = 0; i < n; i++)
        begin
            decoded_q.push_back(outs[i]);
        end
        bytes_sent++;
    endtask

    // Drop valid and hold until every expected beat is out and the pipeline has settled.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_q_mode(input bit v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        q_on = v;
        cfg_writes++;
    endtask

    // Output stalls
    always @(posedge clk)
    begin
        if (rx_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            rx_stall <= pick_gap(rx_calm);
        end
        if ($urandom_range(0, 39) == 0)
        begin
            rx_calm <= !rx_calm;
        end
    end

    always @(posedge clk)
    begin : check_out
        qp_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beats_seen++;
            if (m_axis_tuser)
            begin
                recovered_seen++;
            end
            if (decoded_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: unexpected beat data=%h user=%b last=%b",
                             $realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
            end
            else
            begin
                want = decoded_q.pop_front();
                if (m_axis_tdata !== want.data || m_axis_tuser !== want.rec ||
                    m_axis_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: beat mismatch, expected %h/%b/%b, got %h/%b/%b",
                                 $realtime, want.data, want.rec, want.last,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        dir_row_t row;
        logic [7:0] c;
        int counted;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].q != q_on)
            begin
                wait_idle();
                write_q_mode(dir_rows[i].q);
            end
            send_byte(dir_rows[i]);
        end

        // Random phases, Q mode off, on, off
        for (int p = 0; p < 3; p++)
        begin
            wait_idle();
            write_q_mode(p == 1);
            counted = 0;
            while (counted < 70)
            begin
                plan_token();
                while (plan.size() > 0)
                begin
                    c = plan.pop_front();
                    if (!ignored(c))
                    begin
                        counted++;
                    end
                    row = '0;
                    row.ch = c;
                    send_byte(row);
                end
                // now and then let the output drain completely
                if ($urandom_range(0, 24) == 0)
                begin
                    wait_idle();
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        $display("sent %0d encoded bytes over %0d Q-mode settings; checked %0d decoded beats",
                 bytes_sent, cfg_writes + 1, beats_seen);
        $display("%0d of those beats came from malformed-escape recovery", recovered_seen);
        if (mismatches == 0 && decoded_q.size() == 0)
        begin
            $display("tb_quoted_printable_decoder_top: done, clean");
        end
        else
        begin
            $display("tb_quoted_printable_decoder_top: done, errors");
        end
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("timeout with %0d beats still expected", decoded_q.size());
        $display("tb_quoted_printable_decoder_top: done, errors");
        $finish;
    end

endmodule
